>>> rtl/cfsb_pkg.sv
// Shared types and constants for the checksummed frame sender.
`default_nettype none
package cfsb_pkg;

    localparam int DEF_QUEUE_DEPTH = 4;
    localparam int MAX_RESULTS     = 5;
    localparam int CNT_W           = 3;

    localparam logic [4:0]  MAX_PAYLOAD = 5'd28;
    localparam logic [7:0]  STATUS_OK   = 8'h05;
    localparam logic [7:0]  FAIL_SAT    = 8'hFF;
    localparam logic [15:0] ELAPSED_SAT = 16'hFFFF;

    localparam logic [7:0]  RST_HEADER   = 8'h90;
    localparam logic [7:0]  RST_ADDRESS  = 8'h00;
    localparam logic [7:0]  RST_LIMIT    = 8'd3;
    localparam logic [15:0] RST_INTERVAL = 16'd5000;

    typedef enum logic [1:0] {
        REG_HEADER   = 2'd0,
        REG_ADDRESS  = 2'd1,
        REG_LIMIT    = 2'd2,
        REG_INTERVAL = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        CMD_PAYLOAD  = 2'd0,
        CMD_RESPONSE = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_UNUSED   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_FRAME    = 3'd0,
        KIND_RESYNC   = 3'd1,
        KIND_REJECT   = 3'd2,
        KIND_ACK_OK   = 3'd3,
        KIND_ACK_BAD  = 3'd4,
        KIND_NO_REPLY = 3'd5,
        KIND_OFFLINE  = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } res_t;

    // One request worth of results, slot 0 goes out first
    typedef struct packed {
        logic [CNT_W-1:0]           cnt;
        res_t [MAX_RESULTS-1:0]     res;
    } job_t;

endpackage
`default_nettype wire

>>> rtl/cfsb_front.sv
// Front end: accepts requests, keeps breaker and framing state, builds result jobs.
`default_nettype none
module cfsb_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_idx,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic               accept,
    input  wire logic [1:0]         command,
    input  wire logic [7:0]         data_byte,
    input  wire logic [4:0]         payload_len,
    input  wire logic               resp_present,
    input  wire logic [7:0]         resp_status,
    output logic                    push,
    output cfsb_pkg::job_t          job
);

    logic [7:0]  header_reg, address_reg, limit_reg;
    logic [15:0] interval_reg;

    logic [7:0]  fail_count_reg, fail_count_next;
    logic        offline_reg, offline_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic        in_frame_reg, in_frame_next;
    logic        dropping_reg, dropping_next;
    logic [4:0]  bytes_left_reg, bytes_left_next;
    logic [7:0]  sum_reg, sum_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg     <= cfsb_pkg::RST_HEADER;
            address_reg    <= cfsb_pkg::RST_ADDRESS;
            limit_reg      <= cfsb_pkg::RST_LIMIT;
            interval_reg   <= cfsb_pkg::RST_INTERVAL;
            fail_count_reg <= '0;
            offline_reg    <= 1'b0;
            elapsed_reg    <= '0;
            in_frame_reg   <= 1'b0;
            dropping_reg   <= 1'b0;
            bytes_left_reg <= '0;
            sum_reg        <= '0;
        end else begin
            if (cfg_we) begin
                case (cfsb_pkg::reg_idx_t'(cfg_idx))
                    cfsb_pkg::REG_HEADER:   header_reg   <= cfg_wdata[7:0];
                    cfsb_pkg::REG_ADDRESS:  address_reg  <= cfg_wdata[7:0];
                    cfsb_pkg::REG_LIMIT:    limit_reg    <= cfg_wdata[7:0];
                    cfsb_pkg::REG_INTERVAL: interval_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                fail_count_reg <= fail_count_next;
                offline_reg    <= offline_next;
                elapsed_reg    <= elapsed_next;
                in_frame_reg   <= in_frame_next;
                dropping_reg   <= dropping_next;
                bytes_left_reg <= bytes_left_next;
                sum_reg        <= sum_next;
            end
        end
    end

    logic [4:0] len_clamped;
    logic       drop_window;
    logic [7:0] fail_inc;

    assign len_clamped = (payload_len > cfsb_pkg::MAX_PAYLOAD) ? cfsb_pkg::MAX_PAYLOAD
                                                               : payload_len;
    assign drop_window = offline_reg && (elapsed_reg < interval_reg);
    assign fail_inc    = (fail_count_reg == cfsb_pkg::FAIL_SAT) ? fail_count_reg
                                                               : fail_count_reg + 8'd1;

    always_comb begin
        logic [2:0] n;
        logic [7:0] sum;
        logic [4:0] left;
        logic       drop;
        logic       zero_len;

        n    = '0;
        sum  = sum_reg;
        left = bytes_left_reg;
        drop = dropping_reg;
        zero_len = 1'b0;
        job  = '0;

        fail_count_next = fail_count_reg;
        offline_next    = offline_reg;
        elapsed_next    = elapsed_reg;
        in_frame_next   = in_frame_reg;
        dropping_next   = dropping_reg;
        bytes_left_next = bytes_left_reg;
        sum_next        = sum_reg;

        case (cfsb_pkg::cmd_t'(command))
            cfsb_pkg::CMD_PAYLOAD: begin
                if (!in_frame_reg) begin
                    if (payload_len == 5'd0) begin
                        zero_len = 1'b1;
                        job.res[0] = '{cfsb_pkg::KIND_REJECT, 8'd0};
                        n = 3'd1;
                    end else begin
                        left = len_clamped;
                        if (drop_window) begin
                            drop = 1'b1;
                            job.res[0] = '{cfsb_pkg::KIND_REJECT, 8'd0};
                            n = 3'd1;
                        end else begin
                            // probe or normal frame: emit header, address, length
                            if (offline_reg)
                                fail_count_next = '0;
                            drop = 1'b0;
                            job.res[0] = '{cfsb_pkg::KIND_FRAME, header_reg};
                            job.res[1] = '{cfsb_pkg::KIND_FRAME, address_reg};
                            job.res[2] = '{cfsb_pkg::KIND_FRAME, {3'd0, len_clamped}};
                            sum = header_reg + address_reg + {3'd0, len_clamped};
                            n = 3'd3;
                        end
                    end
                end
                if (!zero_len) begin
                    if (!drop) begin
                        job.res[n] = '{cfsb_pkg::KIND_FRAME, data_byte};
                        sum = sum + data_byte;
                        n = n + 3'd1;
                    end
                    left = left - 5'd1;
                    if (left == 5'd0) begin
                        if (!drop) begin
                            job.res[n] = '{cfsb_pkg::KIND_FRAME, sum};
                            n = n + 3'd1;
                        end
                        in_frame_next = 1'b0;
                        dropping_next = 1'b0;
                    end else begin
                        in_frame_next = 1'b1;
                        dropping_next = drop;
                    end
                    bytes_left_next = left;
                    sum_next        = sum;
                end
            end
            cfsb_pkg::CMD_RESPONSE: begin
                if (!in_frame_reg) begin
                    if (resp_present) begin
                        fail_count_next = '0;
                        offline_next    = 1'b0;
                        job.res[0] = '{(resp_status == cfsb_pkg::STATUS_OK)
                                           ? cfsb_pkg::KIND_ACK_OK
                                           : cfsb_pkg::KIND_ACK_BAD,
                                       8'd0};
                        n = 3'd1;
                    end else begin
                        job.res[0] = '{cfsb_pkg::KIND_RESYNC, 8'd0};
                        fail_count_next = fail_inc;
                        if (fail_inc >= limit_reg) begin
                            offline_next = 1'b1;
                            elapsed_next = '0;
                            job.res[1] = '{cfsb_pkg::KIND_OFFLINE, 8'd0};
                        end else begin
                            job.res[1] = '{cfsb_pkg::KIND_NO_REPLY, 8'd0};
                        end
                        n = 3'd2;
                    end
                end
            end
            cfsb_pkg::CMD_TICK: begin
                if (elapsed_reg != cfsb_pkg::ELAPSED_SAT)
                    elapsed_next = elapsed_reg + 16'd1;
            end
            default: ;
        endcase

        job.cnt = n;
        push    = accept && (n != 3'd0);
    end

    a_drop_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_frame_reg |-> !dropping_reg)
        else $error("dropping flag set outside a frame");

    a_left_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        in_frame_reg |-> (bytes_left_reg != 5'd0 && bytes_left_reg <= cfsb_pkg::MAX_PAYLOAD))
        else $error("frame open with bad byte count");

    a_job_size: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (job.cnt <= 3'd5))
        else $error("job holds more than five results");

endmodule
`default_nettype wire

>>> rtl/cfsb_queue.sv
// Short job queue between the front end and the result sequencer.
`default_nettype none
module cfsb_queue #(
    parameter int DEPTH = cfsb_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire cfsb_pkg::job_t  push_job,
    input  wire logic            pop,
    output logic                 full,
    output logic                 valid,
    output cfsb_pkg::job_t       head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cfsb_pkg::job_t slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign head_job = slots_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: ;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> valid)
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule
`default_nettype wire

>>> rtl/cfsb_back.sv
// Back end: walks each job and drives results through the output register.
`default_nettype none
module cfsb_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    input  wire cfsb_pkg::job_t  q_job,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [7:0]           m_tdata,
    output logic [2:0]           m_tuser,
    output logic                 m_tlast
);

    cfsb_pkg::job_t job_reg, job_next;
    logic [2:0]     idx_reg, idx_next;
    logic           busy_reg, busy_next;
    logic           valid_reg, valid_next;
    cfsb_pkg::res_t res_reg, res_next;
    logic           last_reg, last_next;

    logic advance, at_last;

    assign advance = !valid_reg || m_tready;
    assign at_last = (idx_reg == job_reg.cnt - 3'd1);

    always_comb begin
        job_next   = job_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        valid_next = valid_reg;
        res_next   = res_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;

        if (advance) begin
            valid_next = busy_reg;
            if (busy_reg) begin
                res_next  = job_reg.res[idx_reg];
                last_next = at_last;
                if (at_last)
                    busy_next = 1'b0;
                else
                    idx_next = idx_reg + 3'd1;
            end
        end

        // load the next job as soon as the current one hands out its last result
        if (q_valid && (!busy_reg || (advance && at_last))) begin
            q_pop     = 1'b1;
            job_next  = q_job;
            idx_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg  <= job_next;
        res_reg  <= res_next;
        last_reg <= last_next;
        if (!aresetn) begin
            idx_reg   <= '0;
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.data;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = last_reg;

    a_idx_in_job: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (idx_reg < job_reg.cnt))
        else $error("result index beyond job size");

    a_job_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (job_reg.cnt != 3'd0 && job_reg.cnt <= 3'd5))
        else $error("active job has bad size");

    a_pop_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (busy_reg && idx_reg == 3'd0))
        else $error("popped job not loaded");

endmodule
`default_nettype wire

>>> rtl/checksummed_frame_sender_breaker.sv
// A request's first result goes through the queue slot, job_reg and res_reg to m_tvalid.
// Throughput: one request per cycle is taken while the job queue has room; results leave
// one per cycle while m_tready is high; a request produces up to five results.
// Requests that produce no result (ticks, dropped frame bytes) never enter the queue.
// Reset: synchronous on aresetn low; breaker, framing state and queue clear, registers
// return to header 0x90, address 0, fail limit 3, probe interval 5000 ms.
`default_nettype none
module checksummed_frame_sender_breaker #(
    parameter int QUEUE_DEPTH = cfsb_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_idx,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] data_byte, [12:8] payload_len, [13] resp_present, [21:14] resp_status
    input  wire logic [23:0] s_tdata,
    // [1:0] command
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] out_byte
    output logic [7:0]       m_tdata,
    // [2:0] kind
    output logic [2:0]       m_tuser,
    output logic             m_tlast
);

    logic           accept, push, pop, q_full, q_valid;
    cfsb_pkg::job_t push_job, head_job;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    cfsb_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_wdata    (cfg_wdata),
        .accept       (accept),
        .command      (s_tuser),
        .data_byte    (s_tdata[7:0]),
        .payload_len  (s_tdata[12:8]),
        .resp_present (s_tdata[13]),
        .resp_status  (s_tdata[21:14]),
        .push         (push),
        .job          (push_job)
    );

    cfsb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (q_full),
        .valid    (q_valid),
        .head_job (head_job)
    );

    cfsb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_job    (head_job),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire
